// ----- design/bpmt_pkg.sv -----
`default_nettype none
package bpmt_pkg;

  localparam int ADDR_BITS = 32;
  localparam logic [31:0] ADDR_MASK =
    (ADDR_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_BITS) - 64'd1);

  localparam logic [3:0] NUM_PATTERNS = 4'd14;
  localparam logic [3:0] LAST_PATTERN = 4'd13;
  localparam logic [31:0] LOG_LIMIT = 32'd8;

  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_SLOT  = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_START_ADDRESS = 1'b0;
  localparam logic CFG_REGION_BYTES  = 1'b1;

  localparam logic [3:0] PAT_ZEROS      = 4'd0;
  localparam logic [3:0] PAT_ONES       = 4'd1;
  localparam logic [3:0] PAT_55         = 4'd2;
  localparam logic [3:0] PAT_AA         = 4'd3;
  localparam logic [3:0] PAT_CHECKER    = 4'd4;
  localparam logic [3:0] PAT_CHECKER_N  = 4'd5;
  localparam logic [3:0] PAT_WALK1      = 4'd6;
  localparam logic [3:0] PAT_WALK1_S1   = 4'd7;
  localparam logic [3:0] PAT_WALK0      = 4'd8;
  localparam logic [3:0] PAT_WALK0_S1   = 4'd9;
  localparam logic [3:0] PAT_ADDR       = 4'd10;
  localparam logic [3:0] PAT_ADDR_N     = 4'd11;
  localparam logic [3:0] PAT_ADDR_X5A   = 4'd12;
  localparam logic [3:0] PAT_ADDR_XA5   = 4'd13;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_WRITE = 3'b010,
    PH_READ  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] read_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]  cmd_kind;
    logic [31:0] mem_address;
    logic [7:0]  write_byte;
    logic        checked;
    logic        mismatch;
    logic [7:0]  expected_byte;
    logic        log_worthy;
    logic [3:0]  pattern_index;
    logic [31:0] pattern_errors;
    logic [31:0] total_errors;
    logic        finished;
    logic        test_failed;
  } result_t;

  function automatic logic [7:0] pattern_byte(input logic [3:0] p, input logic [7:0] lo);
    logic [2:0] sh1;
    sh1 = lo[2:0] + 3'd1;
    case (p)
      PAT_ZEROS:     pattern_byte = 8'h00;
      PAT_ONES:      pattern_byte = 8'hFF;
      PAT_55:        pattern_byte = 8'h55;
      PAT_AA:        pattern_byte = 8'hAA;
      PAT_CHECKER:   pattern_byte = lo[0] ? 8'hAA : 8'h55;
      PAT_CHECKER_N: pattern_byte = lo[0] ? 8'h55 : 8'hAA;
      PAT_WALK1:     pattern_byte = 8'd1 << lo[2:0];
      PAT_WALK1_S1:  pattern_byte = 8'd1 << sh1;
      PAT_WALK0:     pattern_byte = ~(8'd1 << lo[2:0]);
      PAT_WALK0_S1:  pattern_byte = ~(8'd1 << sh1);
      PAT_ADDR:      pattern_byte = lo;
      PAT_ADDR_N:    pattern_byte = ~lo;
      PAT_ADDR_X5A:  pattern_byte = lo ^ 8'h5A;
      PAT_ADDR_XA5:  pattern_byte = lo ^ 8'hA5;
      default:       pattern_byte = 8'h00;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- design/byte_pattern_memory_test.sv -----
`default_nettype none
// Channel   Dir  Handshake             Payload
// s_*       in   s_tvalid / s_tready   tuser: req_type; tdata: read_byte
// m_*       out  m_tvalid / m_tready   tuser: cmd_kind; tlast: finished; tdata: fields
// cfg_*     in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high; each item passes the input register, then the result register.
// The whole sequencer step is one pass of combinational logic between the two registers.
// Synchronous reset returns the sequencer to idle with zero counts and clears the valid flags of both registers.
// A stalled m_tready holds the result and the item behind it; s_tready drops once the
// input register is full.
// Configuration writes complete every cycle and are latched into a run by a start item.
module byte_pattern_memory_test (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] read_byte
  input  wire logic [1:0]   s_tuser,   // [1:0] req_type
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [119:0]      m_tdata,   // [31:0] mem_address, [39:32] write_byte,
                                       // [40] checked, [41] mismatch,
                                       // [49:42] expected_byte, [50] log_worthy,
                                       // [54:51] pattern_index, [86:55] pattern_errors,
                                       // [118:87] total_errors, [119] test_failed
  output logic [1:0]        m_tuser,   // [1:0] cmd_kind
  output logic              m_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_data
);

  logic [31:0]       start_address;
  logic [31:0]       region_bytes;
  bpmt_pkg::item_t   s_item;
  bpmt_pkg::item_t   item;
  bpmt_pkg::result_t res;
  logic              item_valid;
  logic              take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= 32'd0;
      region_bytes  <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bpmt_pkg::CFG_START_ADDRESS: start_address <= cfg_data;
        bpmt_pkg::CFG_REGION_BYTES:  region_bytes  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign s_item.req_type  = s_tuser;
  assign s_item.read_byte = s_tdata;

  bpmt_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_item     (s_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  bpmt_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item          (item),
    .take          (take),
    .start_address (start_address),
    .region_bytes  (region_bytes),
    .res_valid     (m_tvalid),
    .res_ready     (m_tready),
    .res           (res)
  );

  assign m_tuser = res.cmd_kind;
  assign m_tlast = res.finished;
  assign m_tdata = {res.test_failed, res.total_errors, res.pattern_errors,
                    res.pattern_index, res.log_worthy, res.expected_byte,
                    res.mismatch, res.checked, res.write_byte, res.mem_address};

endmodule
`default_nettype wire

// ----- design/bpmt_in_stage.sv -----
`default_nettype none
module bpmt_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire bpmt_pkg::item_t s_item,
  input  wire logic            take,
  output logic                 item_valid,
  output bpmt_pkg::item_t      item
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= s_item;
    end
  end

endmodule
`default_nettype wire

// ----- design/bpmt_seq.sv -----
`default_nettype none
module bpmt_seq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire bpmt_pkg::item_t item,
  output logic                 take,
  input  wire logic [31:0]     start_address,
  input  wire logic [31:0]     region_bytes,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output bpmt_pkg::result_t    res
);

  bpmt_pkg::phase_t  phase, phase_next;
  logic [3:0]        pattern_number, pattern_number_next;
  logic [31:0]       issue_offset, issue_offset_next;
  logic [31:0]       check_offset, check_offset_next;
  logic [31:0]       pattern_error_count, pattern_error_count_next;
  logic [31:0]       total_error_count, total_error_count_next;
  logic [31:0]       run_start, run_start_next;
  logic [31:0]       run_bytes, run_bytes_next;
  bpmt_pkg::result_t res_next;

  logic [31:0] issue_addr, check_addr, issue_inc, check_inc, perr_report;
  logic        fin;

  assign take       = item_valid && (!res_valid || res_ready);
  assign issue_addr = (run_start + issue_offset) & bpmt_pkg::ADDR_MASK;
  assign check_addr = (run_start + check_offset) & bpmt_pkg::ADDR_MASK;
  assign issue_inc  = issue_offset + 32'd1;
  assign check_inc  = check_offset + 32'd1;

  always_comb begin
    phase_next               = phase;
    pattern_number_next      = pattern_number;
    issue_offset_next        = issue_offset;
    check_offset_next        = check_offset;
    pattern_error_count_next = pattern_error_count;
    total_error_count_next   = total_error_count;
    run_start_next           = run_start;
    run_bytes_next           = run_bytes;
    res_next                 = '0;
    res_next.pattern_index   = pattern_number;
    fin                      = 1'b0;
    perr_report              = 32'd0;

    case (item.req_type)
      bpmt_pkg::REQ_START: begin
        run_start_next           = start_address;
        run_bytes_next           = region_bytes;
        issue_offset_next        = 32'd0;
        check_offset_next        = 32'd0;
        pattern_error_count_next = 32'd0;
        total_error_count_next   = 32'd0;
        if (region_bytes == 32'd0) begin
          pattern_number_next = bpmt_pkg::LAST_PATTERN;
          phase_next          = bpmt_pkg::PH_IDLE;
          fin                 = 1'b1;
        end else begin
          pattern_number_next = 4'd0;
          phase_next          = bpmt_pkg::PH_WRITE;
        end
        res_next.pattern_index = pattern_number_next;
      end
      bpmt_pkg::REQ_SLOT: begin
        if (phase == bpmt_pkg::PH_WRITE) begin
          res_next.cmd_kind    = bpmt_pkg::CMD_WRITE;
          res_next.mem_address = issue_addr;
          res_next.write_byte  = bpmt_pkg::pattern_byte(pattern_number, issue_addr[7:0]);
          if (issue_inc >= run_bytes) begin
            phase_next        = bpmt_pkg::PH_READ;
            issue_offset_next = 32'd0;
            check_offset_next = 32'd0;
          end else begin
            issue_offset_next = issue_inc;
          end
        end else if (phase == bpmt_pkg::PH_READ && issue_offset < run_bytes) begin
          res_next.cmd_kind    = bpmt_pkg::CMD_READ;
          res_next.mem_address = issue_addr;
          issue_offset_next    = issue_inc;
        end
      end
      bpmt_pkg::REQ_DATA: begin
        if (phase == bpmt_pkg::PH_READ && check_offset < issue_offset) begin
          res_next.checked       = 1'b1;
          res_next.expected_byte = bpmt_pkg::pattern_byte(pattern_number, check_addr[7:0]);
          if (item.read_byte != res_next.expected_byte) begin
            res_next.mismatch   = 1'b1;
            res_next.log_worthy = pattern_error_count < bpmt_pkg::LOG_LIMIT;
            if (pattern_error_count != 32'hFFFF_FFFF) begin
              pattern_error_count_next = pattern_error_count + 32'd1;
            end
            if (total_error_count != 32'hFFFF_FFFF) begin
              total_error_count_next = total_error_count + 32'd1;
            end
          end
          check_offset_next = check_inc;
          if (check_inc >= run_bytes) begin
            if (pattern_number >= bpmt_pkg::LAST_PATTERN) begin
              phase_next = bpmt_pkg::PH_IDLE;
              fin        = 1'b1;
            end else begin
              perr_report              = pattern_error_count_next;
              pattern_number_next      = pattern_number + 4'd1;
              pattern_error_count_next = 32'd0;
              issue_offset_next        = 32'd0;
              check_offset_next        = 32'd0;
              phase_next               = bpmt_pkg::PH_WRITE;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (pattern_number_next != pattern_number && item.req_type == bpmt_pkg::REQ_DATA) begin
      res_next.pattern_errors = perr_report;
    end else begin
      res_next.pattern_errors = pattern_error_count_next;
    end
    res_next.total_errors = total_error_count_next;
    res_next.finished     = fin;
    res_next.test_failed  = fin && (total_error_count_next != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= bpmt_pkg::PH_IDLE;
      pattern_number      <= 4'd0;
      issue_offset        <= 32'd0;
      check_offset        <= 32'd0;
      pattern_error_count <= 32'd0;
      total_error_count   <= 32'd0;
      run_start           <= 32'd0;
      run_bytes           <= 32'd0;
      res_valid           <= 1'b0;
    end else begin
      if (take) begin
        phase               <= phase_next;
        pattern_number      <= pattern_number_next;
        issue_offset        <= issue_offset_next;
        check_offset        <= check_offset_next;
        pattern_error_count <= pattern_error_count_next;
        total_error_count   <= total_error_count_next;
        run_start           <= run_start_next;
        run_bytes           <= run_bytes_next;
      end
      if (!res_valid || res_ready) begin
        res_valid <= item_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire
